/* src/swt_pkg.sv */
// Shared constants and types for the shell word tokenizer.
package swt_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic [CFG_W-1:0] MAX_WORDS_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_MANY     = 3'd1,
    ST_META         = 3'd2,
    ST_OPEN_QUOTE   = 3'd3,
    ST_TRAIL_BSLASH = 3'd4
  } swt_status_t;

  typedef struct packed {
    logic               has_char;
    logic [7:0]         out_char;
    logic [IDX_W-1:0]   word_index;
    logic               word_end;
    logic               line_end;
    logic [COUNT_W-1:0] word_count;
    swt_status_t        status;
  } swt_res_t;

endpackage

/* src/swt_char_if.sv */
// Input channel: one line character per transfer.
interface swt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

/* src/swt_tok_if.sv */
// Result channel: word characters, word ends and line ends.
interface swt_tok_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] out_char;
  logic [3:0] word_index;
  logic       word_end;
  logic       line_end;
  logic [4:0] word_count;
  logic [2:0] status;

  modport source (output valid, output has_char, output out_char, output word_index,
                  output word_end, output line_end, output word_count, output status,
                  input ready);
  modport sink   (input valid, input has_char, input out_char, input word_index,
                  input word_end, input line_end, input word_count, input status,
                  output ready);
endinterface

/* src/swt_core.sv */
// Tokenizer state and the per-character step logic.
module swt_core #(
  parameter int MAX_WORDS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  ch,
  input  logic [swt_pkg::CFG_W-1:0]   max_words,
  output logic                        emit,
  output swt_pkg::swt_res_t           res
);
  import swt_pkg::*;

  localparam int WW = $clog2(MAX_WORDS + 1);
  localparam int LW = (WW > 5) ? WW : 5;

  typedef enum logic [2:0] {
    M_BETWEEN,
    M_WORD,
    M_QUOTED,
    M_ESCAPE,
    M_DROP
  } mode_t;

  mode_t        mode_r, mode_nxt;
  logic         quote_kind_r, quote_kind_nxt;
  logic         esc_q_r, esc_q_nxt;
  logic [WW-1:0] words_r, words_nxt;
  swt_status_t  pend_r, pend_nxt;

  logic [LW-1:0] lim;
  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] words_ext;
  logic [LW-1:0] idx_full;
  logic          blank;
  logic          is_meta;
  logic          do_unq;
  logic          r_has, r_wend, r_lend;
  swt_status_t   r_st;

  assign cfg_ext   = LW'(max_words);
  assign lim       = (cfg_ext > LW'(MAX_WORDS)) ? LW'(MAX_WORDS) : cfg_ext;
  assign words_ext = LW'(words_r);
  assign blank     = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_meta   = (ch == CH_PIPE) || (ch == CH_GT) || (ch == CH_LT) ||
                     (ch == CH_AMP) || (ch == CH_STAR);

  always_comb begin
    mode_nxt       = mode_r;
    quote_kind_nxt = quote_kind_r;
    esc_q_nxt      = esc_q_r;
    words_nxt      = words_r;
    pend_nxt       = pend_r;
    do_unq         = 1'b0;
    r_has          = 1'b0;
    r_wend         = 1'b0;
    r_lend         = 1'b0;
    r_st           = ST_OK;

    unique case (mode_r)
      M_BETWEEN: begin
        if (ch == CH_NUL) begin
          r_lend = 1'b1;
        end else if (!blank) begin
          if (words_ext >= lim) begin
            pend_nxt = ST_TOO_MANY;
            mode_nxt = M_DROP;
          end else begin
            words_nxt = words_r + WW'(1);
            mode_nxt  = M_WORD;
            do_unq    = 1'b1;
          end
        end
      end
      M_WORD: begin
        if (ch == CH_NUL) begin
          r_lend = 1'b1;
          r_wend = 1'b1;
        end else if (blank) begin
          mode_nxt = M_BETWEEN;
          r_wend   = 1'b1;
        end else begin
          do_unq = 1'b1;
        end
      end
      M_QUOTED: begin
        if (ch == CH_NUL) begin
          r_lend = 1'b1;
          r_st   = ST_OPEN_QUOTE;
        end else if (ch == CH_BSLASH) begin
          mode_nxt  = M_ESCAPE;
          esc_q_nxt = 1'b1;
        end else if (ch == (quote_kind_r ? CH_DQUOTE : CH_SQUOTE)) begin
          mode_nxt = M_WORD;
        end else begin
          r_has = 1'b1;
        end
      end
      M_ESCAPE: begin
        if (ch == CH_NUL) begin
          r_lend = 1'b1;
          r_st   = ST_TRAIL_BSLASH;
        end else begin
          mode_nxt  = esc_q_r ? M_QUOTED : M_WORD;
          esc_q_nxt = 1'b0;
          r_has     = 1'b1;
        end
      end
      M_DROP: begin
        if (ch == CH_NUL) begin
          r_lend = 1'b1;
          r_st   = pend_r;
        end
      end
      default: begin
        mode_nxt = M_BETWEEN;
      end
    endcase

    // unquoted word character handling
    if (do_unq) begin
      priority if (ch == CH_BSLASH) begin
        mode_nxt  = M_ESCAPE;
        esc_q_nxt = 1'b0;
      end else if ((ch == CH_SQUOTE) || (ch == CH_DQUOTE)) begin
        mode_nxt       = M_QUOTED;
        quote_kind_nxt = (ch == CH_DQUOTE);
      end else if (is_meta) begin
        pend_nxt = ST_META;
        mode_nxt = M_DROP;
      end else begin
        r_has = 1'b1;
      end
    end

    if (r_lend) begin
      mode_nxt       = M_BETWEEN;
      quote_kind_nxt = 1'b0;
      esc_q_nxt      = 1'b0;
      words_nxt      = '0;
      pend_nxt       = ST_OK;
    end
  end

  // index of the current word, taken after a word start in this step
  always_comb begin
    idx_full = (words_nxt != '0 && !r_lend) ? LW'(words_nxt) - LW'(1) :
               (words_r != '0)              ? words_ext - LW'(1) : '0;
  end

  assign emit = r_has || r_wend || r_lend;

  always_comb begin
    res            = '0;
    res.has_char   = r_has;
    res.out_char   = r_has ? ch : 8'h00;
    res.word_index = (r_has || r_wend) ? idx_full[IDX_W-1:0] : '0;
    res.word_end   = r_wend;
    res.line_end   = r_lend;
    res.word_count = r_lend ? words_ext[COUNT_W-1:0] : '0;
    res.status     = r_lend ? r_st : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_BETWEEN;
      quote_kind_r <= 1'b0;
      esc_q_r      <= 1'b0;
      words_r      <= '0;
      pend_r       <= ST_OK;
    end else if (step) begin
      mode_r       <= mode_nxt;
      quote_kind_r <= quote_kind_nxt;
      esc_q_r      <= esc_q_nxt;
      words_r      <= words_nxt;
      pend_r       <= pend_nxt;
    end
  end

endmodule

/* src/shell_word_tokenizer.sv */
// Streaming shell command-line word splitter, top level.
// Path: input register, then step logic into the result register.
// Throughput: one character per cycle unless the output stalls; the input
// and result registers hold one entry each, so input stalls only once both
// are full and out_chan.ready is low.
// Reset (rst_n low, synchronous): channels empty, max_words back to 16,
// tokenizer between words with no words counted.
module shell_word_tokenizer #(
  parameter int MAX_WORDS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  swt_char_if.sink                  in_chan,
  swt_tok_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [swt_pkg::CFG_W-1:0] cfg_data
);
  import swt_pkg::*;

  logic [CFG_W-1:0]   max_words_val_r;
  logic               in_valid_r;
  logic [7:0]         ch_r;
  logic               out_valid_r;
  swt_res_t           res_r;
  swt_res_t           res;
  logic               emit;
  logic               adv;
  logic               step;

  assign adv          = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !in_valid_r || adv;
  assign step         = in_valid_r && adv;

  swt_core #(
    .MAX_WORDS(MAX_WORDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (ch_r),
    .max_words (max_words_val_r),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_words_val_r <= MAX_WORDS_RST;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_words_val_r <= cfg_data;
      end
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (adv) begin
        out_valid_r <= step && emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      ch_r <= in_chan.ch;
    end
    if (adv && step) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.has_char   = res_r.has_char;
  assign out_chan.out_char   = res_r.out_char;
  assign out_chan.word_index = res_r.word_index;
  assign out_chan.word_end   = res_r.word_end;
  assign out_chan.line_end   = res_r.line_end;
  assign out_chan.word_count = res_r.word_count;
  assign out_chan.status     = res_r.status;

endmodule
